FILE: rtl/vfc_pkg.sv
// shared types and constants for the voxel face culling block
// no dependencies; used by voxel_face_culling and vfc_addr
`default_nettype none

package vfc_pkg;

	localparam int DEF_CHUNK_EDGE = 16;
	localparam int DEF_TYPE_BITS  = 8;

	localparam int COORD_W = 4;
	localparam int TYPE_W  = 8;
	localparam int CHUNK_W = 16;
	localparam int WORLD_W = 20;
	localparam int FACE_W  = 3;
	localparam int NUM_FACES = 6;
	localparam int CFG_IDX_W = 2;

	// face codes, also the order in which faces are probed and emitted
	localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd0;
	localparam logic [FACE_W-1:0] FACE_BACK   = 3'd1;
	localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd2;
	localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd3;
	localparam logic [FACE_W-1:0] FACE_TOP    = 3'd4;
	localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd5;

	// operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_MESH  = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_Z = 2'd2;

	typedef struct packed {
		logic               operation;
		logic [COORD_W-1:0] local_x;
		logic [COORD_W-1:0] local_y;
		logic [COORD_W-1:0] local_z;
		logic [TYPE_W-1:0]  voxel_type;
	} req_item_t;

	typedef struct packed {
		logic signed [WORLD_W-1:0] world_x;
		logic signed [WORLD_W-1:0] world_y;
		logic signed [WORLD_W-1:0] world_z;
		logic [FACE_W-1:0]         face;
		logic                      last;
	} rsp_item_t;

	// one probe of the store: the centre voxel or one of its neighbours
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic               centre;
		logic [FACE_W-1:0]  face;
	} probe_t;

endpackage

`default_nettype wire

FILE: rtl/voxel_face_culling.sv
// top level of the voxel face culling block: sequencer, registers and output stage
// depends on vfc_pkg, vfc_addr and vfc_ram
`default_nettype none

// Keeps a cubic chunk of CHUNK_EDGE^3 voxel type codes in one memory and answers
// two kinds of item. A write item stores a type code (0 is air). A mesh item probes
// the named voxel and its six neighbours one address per cycle through a single
// shared address unit and the memory read port; if the named voxel is solid it then
// emits one result per air neighbour, in the order front, back, left, right, top,
// bottom, with last set on the final one; neighbours outside the chunk count as air.
// The seven reads go serially through the single read port, and faces are emitted
// one per cycle while the output register is free; a full output register waiting
// on rsp_stall holds the emission back. The results carry the world position
// chunk * CHUNK_EDGE + local, wrapped to 20 bits. After reset the block clears the
// whole memory to air, one entry per cycle, all CHUNK_EDGE^3 entries (4096 at the
// default edge), and holds req_stall high meanwhile; chunk registers can be written
// at any time the block is idle.
module voxel_face_culling import vfc_pkg::*; #(
	parameter int CHUNK_EDGE = DEF_CHUNK_EDGE,
	parameter int TYPE_BITS  = DEF_TYPE_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// item channel
	input  wire logic                 req_valid,
	output logic                      req_stall,
	input  wire req_item_t            req,
	// result channel
	output logic                      rsp_valid,
	input  wire logic                 rsp_stall,
	output rsp_item_t                 rsp,
	// configuration writes
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CHUNK_W-1:0]   cfg_data
);

	localparam int CELLS  = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
	localparam int ADDR_W = $clog2(CELLS);
	localparam logic [2:0] STEP_CENTRE = 3'd0;
	localparam logic [2:0] STEP_LAST   = 3'd6;  // bottom neighbour
	localparam logic [2:0] STEP_DRAIN  = 3'd7;  // no read, last data returning

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_EMIT} state_t;

	state_t                   state_q;
	logic [ADDR_W-1:0]        clr_q;
	logic [CHUNK_W-1:0]       chunk_x_q, chunk_y_q, chunk_z_q;
	logic [COORD_W-1:0]       x_q, y_q, z_q;
	logic signed [WORLD_W-1:0] world_x_q, world_y_q, world_z_q;
	logic [2:0]               step_q;
	logic                     rd_s1;
	logic [2:0]               step_s1;
	logic                     inb_s1;
	logic                     solid_q;
	logic [NUM_FACES-1:0]     mask_q;
	logic                     rsp_valid_q;
	rsp_item_t                rsp_q;

	probe_t                   probe;
	logic [ADDR_W-1:0]        probe_addr;
	logic                     probe_inb;
	logic                     ram_we;
	logic [ADDR_W-1:0]        ram_waddr;
	logic [TYPE_BITS-1:0]     ram_wdata;
	logic [TYPE_BITS-1:0]     ram_rdata;
	logic                     accept;
	logic                     air;
	logic [NUM_FACES-1:0]     pend;
	logic [NUM_FACES-1:0]     rest;
	logic [FACE_W-1:0]        sel;
	logic                     slot_free;
	logic                     emit;

	function automatic logic signed [WORLD_W-1:0] world_of(
		input logic [CHUNK_W-1:0] c,
		input logic [COORD_W-1:0] l
	);
		int w;
		w = int'($signed(c)) * CHUNK_EDGE + int'(l);
		return WORLD_W'(w);
	endfunction

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);

	// the probe unit serves the write address while idle, the seven probes otherwise
	always_comb begin
		if (state_q == ST_IDLE) begin
			probe.x      = req.local_x;
			probe.y      = req.local_y;
			probe.z      = req.local_z;
			probe.centre = 1'b1;
			probe.face   = FACE_FRONT;
		end else begin
			probe.x      = x_q;
			probe.y      = y_q;
			probe.z      = z_q;
			probe.centre = (step_q == STEP_CENTRE);
			probe.face   = 3'(step_q - 3'd1);
		end
	end

	vfc_addr #(
		.CHUNK_EDGE(CHUNK_EDGE)
	) u_addr (
		.probe(probe),
		.addr (probe_addr),
		.inb  (probe_inb)
	);

	// clearing pass owns the write port after reset; writes outside the chunk are dropped
	assign ram_we    = (state_q == ST_CLEAR)
		|| (accept && (req.operation == OP_WRITE) && probe_inb);
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : probe_addr;
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : TYPE_BITS'(req.voxel_type);

	vfc_ram #(
		.WIDTH(TYPE_BITS),
		.DEPTH(CELLS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(probe_addr),
		.rdata(ram_rdata)
	);

	// returning read: out of bounds or a zero code is air
	assign air = !inb_s1 || (ram_rdata == '0);

	// faces still to emit, lowest code first
	assign pend = mask_q & {NUM_FACES{solid_q}};
	always_comb begin
		sel = '0;
		for (int i = NUM_FACES - 1; i >= 0; i--) begin
			if (pend[i]) begin
				sel = FACE_W'(i);
			end
		end
	end
	assign rest      = pend & ~(NUM_FACES'(1) << sel);
	assign slot_free = !rsp_valid_q || !rsp_stall;
	// a face goes into the output register this cycle
	assign emit      = (state_q == ST_EMIT) && slot_free && (pend != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			chunk_x_q   <= '0;
			chunk_y_q   <= '0;
			chunk_z_q   <= '0;
			x_q         <= '0;
			y_q         <= '0;
			z_q         <= '0;
			world_x_q   <= '0;
			world_y_q   <= '0;
			world_z_q   <= '0;
			step_q      <= '0;
			rd_s1       <= 1'b0;
			step_s1     <= '0;
			inb_s1      <= 1'b0;
			solid_q     <= 1'b0;
			mask_q      <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_CHUNK_X: chunk_x_q <= cfg_data;
					CFG_CHUNK_Y: chunk_y_q <= cfg_data;
					CFG_CHUNK_Z: chunk_z_q <= cfg_data;
					default: ;
				endcase
			end

			// output register empties once its item is taken, unless refilled
			if (rsp_valid_q && !rsp_stall && !emit) begin
				rsp_valid_q <= 1'b0;
			end

			// read pipeline: probe issued this cycle, data back next
			rd_s1   <= (state_q == ST_READ) && (step_q != STEP_DRAIN);
			step_s1 <= step_q;
			inb_s1  <= probe_inb;
			if (rd_s1) begin
				if (step_s1 == STEP_CENTRE) begin
					solid_q <= !air;
				end else begin
					mask_q[3'(step_s1 - 3'd1)] <= air;
				end
			end

			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && (req.operation == OP_MESH)) begin
						x_q       <= req.local_x;
						y_q       <= req.local_y;
						z_q       <= req.local_z;
						world_x_q <= world_of(chunk_x_q, req.local_x);
						world_y_q <= world_of(chunk_y_q, req.local_y);
						world_z_q <= world_of(chunk_z_q, req.local_z);
						step_q    <= STEP_CENTRE;
						state_q   <= ST_READ;
					end
				end
				ST_READ: begin
					if (step_q != STEP_DRAIN) begin
						step_q <= step_q + 3'd1;
					end
					// bottom neighbour data lands at this edge
					if (rd_s1 && (step_s1 == STEP_LAST)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						if (pend == '0) begin
							state_q <= ST_IDLE;
						end else begin
							rsp_valid_q   <= 1'b1;
							rsp_q.world_x <= world_x_q;
							rsp_q.world_y <= world_y_q;
							rsp_q.world_z <= world_z_q;
							rsp_q.face    <= sel;
							rsp_q.last    <= (rest == '0);
							mask_q        <= rest;
							if (rest == '0) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

FILE: rtl/vfc_ram.sv
// generic single write, single read memory with registered read data
// no dependencies
`default_nettype none

module vfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/vfc_addr.sv
// shared probe unit: neighbour offset, bounds check and linear store address
// depends on vfc_pkg
`default_nettype none

module vfc_addr import vfc_pkg::*; #(
	parameter int CHUNK_EDGE = DEF_CHUNK_EDGE,
	localparam int ADDR_W = $clog2(CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE)
) (
	input  wire probe_t            probe,
	output logic [ADDR_W-1:0]      addr,
	output logic                   inb
);

	logic [COORD_W:0] nx, ny, nz;
	logic             under;

	always_comb begin
		nx = {1'b0, probe.x};
		ny = {1'b0, probe.y};
		nz = {1'b0, probe.z};
		under = 1'b0;
		if (!probe.centre) begin
			case (probe.face)
				FACE_FRONT:  nz = nz + (COORD_W+1)'(1);
				FACE_BACK: begin
					under = (probe.z == '0);
					nz = nz - (COORD_W+1)'(1);
				end
				FACE_LEFT: begin
					under = (probe.x == '0);
					nx = nx - (COORD_W+1)'(1);
				end
				FACE_RIGHT:  nx = nx + (COORD_W+1)'(1);
				FACE_TOP:    ny = ny + (COORD_W+1)'(1);
				FACE_BOTTOM: begin
					under = (probe.y == '0);
					ny = ny - (COORD_W+1)'(1);
				end
				default: ;
			endcase
		end
	end

	// anything outside the chunk reads as air
	assign inb = !under && (int'(nx) < CHUNK_EDGE) && (int'(ny) < CHUNK_EDGE)
		&& (int'(nz) < CHUNK_EDGE);

	assign addr = ADDR_W'((int'(nx) * CHUNK_EDGE + int'(ny)) * CHUNK_EDGE + int'(nz));

endmodule

`default_nettype wire
